/* rtl/rfa_pkg.sv */
`default_nettype none

package rfa_pkg;

  localparam int NUM_FRAMES = 1024;
  localparam int COUNT_BITS = 8;
  localparam int FRAME_W    = 10;
  localparam int DEPTH_W    = 11;
  localparam int IDX_W      = $clog2(NUM_FRAMES);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_ADD   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_HELD  = 2'd2,
    ST_UNREF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

/* rtl/refcounted_frame_allocator.sv */
`default_nettype none

// Reference counted page frame allocator.
// Requests: drive command and frame_in with start high; the item is
// taken at the clock edge where start is high and busy is low. Allocate
// pops the most recently freed or added frame and sets its count to 1;
// free decrements a count and returns the frame to the pool at zero; add
// seeds the pool with a frame.
// Results: one per item, shown on frame_out, status and free_count for a
// single cycle while done is high. The receiver cannot stall; each result
// is presented once and not held.
// Timing: an item is taken in the idle state, the two memories (free stack
// and count table) are read at that edge, and the following cycle performs
// the read-modify-write; done is high the cycle after. Busy is high for one
// cycle per item, so no new item is taken while one executes, and the
// result is visible alongside the next accept.
// Reset: rst clears the pool depth and starts a clearing pass over the
// count table, one entry a cycle, over all 1024 entries with busy high.
module refcounted_frame_allocator
  import rfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           command,
  input  wire logic [FRAME_W-1:0]   frame_in,
  output logic                      done,
  output logic [FRAME_W-1:0]        frame_out,
  output logic [1:0]                status,
  output logic [DEPTH_W-1:0]        free_count
);

  logic [FRAME_W-1:0]    stk_mem [NUM_FRAMES];
  logic [COUNT_BITS-1:0] ref_mem [NUM_FRAMES];

  state_t                state, state_next;
  logic [IDX_W-1:0]      clr_idx, clr_idx_next;
  logic [DEPTH_W-1:0]    depth, depth_next;
  logic [1:0]            cmd_q;
  logic [FRAME_W-1:0]    frame_q;
  logic [FRAME_W-1:0]    stk_rd;
  logic [COUNT_BITS-1:0] ref_rd;

  logic                  ref_we;
  logic [IDX_W-1:0]      ref_waddr;
  logic [COUNT_BITS-1:0] ref_wdata;
  logic                  stk_we;
  logic [FRAME_W-1:0]    stk_wdata;
  logic                  done_next;
  logic [FRAME_W-1:0]    frame_out_next;
  status_t               status_next;

  logic [DEPTH_W-1:0]    depth_m1;
  logic                  accept;
  logic                  frame_bad;
  logic                  pool_full;

  assign accept    = start && !busy;
  assign depth_m1  = depth - DEPTH_W'(1);
  assign frame_bad = {{(DEPTH_W-FRAME_W){1'b0}}, frame_q} >= DEPTH_W'(NUM_FRAMES);
  assign pool_full = depth >= DEPTH_W'(NUM_FRAMES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      depth   <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      depth   <= depth_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      frame_q <= frame_in;
    end
    if (done_next) begin
      frame_out  <= frame_out_next;
      status     <= status_next;
      free_count <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    ref_rd <= ref_mem[frame_in[IDX_W-1:0]];
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
  end

  always_ff @(posedge clk) begin
    stk_rd <= stk_mem[depth_m1[IDX_W-1:0]];
    if (stk_we) begin
      stk_mem[depth[IDX_W-1:0]] <= stk_wdata;
    end
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    depth_next     = depth;
    busy           = 1'b1;
    done_next      = 1'b0;
    ref_we         = 1'b0;
    ref_waddr      = frame_q[IDX_W-1:0];
    ref_wdata      = '0;
    stk_we         = 1'b0;
    stk_wdata      = frame_q;
    frame_out_next = frame_q;
    status_next    = ST_OK;
    unique case (state)
      S_CLEAR: begin
        ref_we       = 1'b1;
        ref_waddr    = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(NUM_FRAMES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (cmd_q)
          CMD_ALLOC: begin
            if (depth == '0) begin
              frame_out_next = '0;
              status_next    = ST_EMPTY;
            end else begin
              depth_next     = depth_m1;
              frame_out_next = stk_rd;
              ref_we         = 1'b1;
              ref_waddr      = stk_rd[IDX_W-1:0];
              ref_wdata      = COUNT_BITS'(1);
            end
          end
          CMD_FREE: begin
            if (frame_bad || ref_rd == '0) begin
              status_next = ST_UNREF;
            end else if (ref_rd > COUNT_BITS'(1)) begin
              ref_we      = 1'b1;
              ref_wdata   = ref_rd - COUNT_BITS'(1);
              status_next = ST_HELD;
            end else if (pool_full) begin
              status_next = ST_EMPTY;
            end else begin
              ref_we     = 1'b1;
              ref_wdata  = '0;
              stk_we     = 1'b1;
              depth_next = depth + DEPTH_W'(1);
            end
          end
          CMD_ADD: begin
            if (frame_bad) begin
              status_next = ST_UNREF;
            end else if (ref_rd != '0) begin
              status_next = ST_HELD;
            end else if (pool_full) begin
              status_next = ST_EMPTY;
            end else begin
              stk_we     = 1'b1;
              depth_next = depth + DEPTH_W'(1);
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire
